// File: hw/rtl/job_slot_dispatcher_assert.svh
// Assertion macros shared by the job slot dispatcher RTL.
// Depends on nothing; included inside the module body that uses it.
`ifndef JOB_SLOT_DISPATCHER_ASSERT_SVH
`define JOB_SLOT_DISPATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jsd_pkg.sv
// Package for the job slot dispatcher: operation, state and status codes,
// the slot record type and its reset value. Depends on nothing.
package jsd_pkg;

    localparam int MAX_SLOTS_DEF = 16;

    // Operation codes
    localparam logic [2:0] OP_CLAIM    = 3'd0;
    localparam logic [2:0] OP_COMPLETE = 3'd1;
    localparam logic [2:0] OP_CANCEL   = 3'd2;
    localparam logic [2:0] OP_RETRY    = 3'd3;
    localparam logic [2:0] OP_GET      = 3'd4;

    // Slot states
    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_RUNNING   = 3'd1;
    localparam logic [2:0] ST_SUCCEEDED = 3'd2;
    localparam logic [2:0] ST_FAILED    = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    // Status codes of a result
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_INVALID = 2'd1;
    localparam logic [1:0] RES_BLOCK   = 2'd2;
    localparam logic [1:0] RES_EMPTY   = 2'd3;

    // Completion and result codes
    localparam logic [7:0] CODE_SUCCESS = 8'd0;
    localparam logic [7:0] CODE_CANCEL  = 8'd1;
    localparam logic [7:0] CODE_CAPPED  = 8'd254;
    localparam logic [7:0] NO_RESULT    = 8'd255;

    localparam logic [31:0] RETRY_MAX = 32'hFFFF_FFFF;
    localparam logic [4:0]  COUNT_MAX = 5'd31;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_SLOTS = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_PAUSE = 2'd2;
    localparam logic [4:0] SLOTS_RESET = 5'd16;
    localparam logic [4:0] LIMIT_RESET = 5'd1;

    typedef struct packed {
        logic [2:0]  state;
        logic [63:0] started;
        logic [63:0] finished;
        logic [31:0] retries;
        logic [7:0]  result;
    } t_rec;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  claimed_slot;
        logic [4:0]  cancelled_count;
        logic [2:0]  slot_state_out;
        logic [63:0] slot_started;
        logic [63:0] slot_finished;
        logic [31:0] slot_retries;
        logic [7:0]  slot_result;
    } t_result;

    localparam t_rec REC_RESET = '{
        state:    ST_QUEUED,
        started:  64'd0,
        finished: 64'd0,
        retries:  32'd0,
        result:   NO_RESULT
    };

endpackage

// File: hw/rtl/job_slot_dispatcher.sv
// Job slot dispatcher top level: slot table memory, scan sequencer and
// stream ports. Depends on jsd_pkg and job_slot_dispatcher_assert.svh.

// The block keeps a table of MAX_SLOTS job slots in one memory with a
// registered read port and one write port; a valid bit per slot makes an
// unwritten slot read as queued with zero times, zero retries and no result,
// so no clearing pass follows reset. One command is a stream transaction on
// the slave side and yields exactly one result transaction on the master
// side. The block handles one command at a time. A claim or a cancel walks
// the slots from index zero through the memory port, one slot per cycle,
// with the read of the next slot overlapped with the update of the current
// one. Complete, retry and get read a single slot, and complete and retry
// may update it. Refusals that need no slot (paused or limit reached, slot
// out of range, unknown operation) are given without reading the table.
// The next command is taken in the cycle after the result is loaded into
// the output register, even while that result still waits on the master
// side. Configuration writes go straight into their registers and must
// only be issued while the block is idle; they never touch the slot table
// or the running job count.
module job_slot_dispatcher
    import jsd_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [4:0]   i_cfg_data,
    // Command stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], slot_index[6:3], time_now[70:7], completion_code[78:71],
    // status_present[79]
    input  logic [79:0]  s_axis_tdata,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], claimed_slot[5:2], cancelled_count[10:6],
    // slot_state_out[13:11], slot_started[77:14], slot_finished[141:78],
    // slot_retries[173:142], slot_result[181:174], zero fill[183:182]
    output logic [183:0] m_axis_tdata
);

    // Address width of the table and width of a counter that reaches
    // MAX_SLOTS itself.
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Configuration registers
    logic [4:0] r_slots;
    logic [4:0] r_limit;
    logic       r_pause;

    // Sequencer and command registers
    logic [2:0]    r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [AW-1:0] r_addr, n_addr;
    logic [63:0]   r_time, n_time;
    logic [7:0]    r_code, n_code;
    logic          r_present, n_present;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_eval_idx, n_eval_idx;
    logic [4:0]    r_count, n_count;
    logic [4:0]    r_active, n_active;
    t_result       r_res, n_res;

    // Output register
    logic         r_out_valid;
    logic [183:0] r_out_data;
    logic         out_load;

    // Slot table
    t_rec           r_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_valid;
    t_rec           r_rd_data;
    logic           r_rd_vld;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    t_rec           mem_wdata;

    // Decoded command fields
    logic [2:0]    in_op;
    logic [3:0]    in_slot;
    logic [63:0]   in_time;
    logic [7:0]    in_code;
    logic          in_present;

    logic [CW-1:0] live_n;
    logic          in_range;
    t_rec          eval_rec;
    logic          hit;
    logic [4:0]    count_inc;

    assign in_op      = s_axis_tdata[2:0];
    assign in_slot    = s_axis_tdata[6:3];
    assign in_time    = s_axis_tdata[70:7];
    assign in_code    = s_axis_tdata[78:71];
    assign in_present = s_axis_tdata[79];

    // Slots in use above the table depth count as the full table.
    assign live_n   = (32'(r_slots) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(r_slots);
    assign in_range = 32'(in_slot) < 32'(live_n);

    // A slot never written since reset reads as its reset record.
    assign eval_rec  = r_rd_vld ? r_rd_data : REC_RESET;
    assign hit       = r_pend && (eval_rec.state == ST_QUEUED);
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 5'd1;

    // During a scan the counter addresses the table; otherwise the slot
    // named by the command does.
    assign rd_addr = (r_state == S_SCAN) ? r_idx[AW-1:0] : r_addr;

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_addr     = r_addr;
        n_time     = r_time;
        n_code     = r_code;
        n_present  = r_present;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_eval_idx = r_eval_idx;
        n_count    = r_count;
        n_active   = r_active;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_eval_idx;
        mem_wdata  = eval_rec;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op      = in_op;
                    n_addr    = AW'(32'(in_slot));
                    n_time    = in_time;
                    n_code    = in_code;
                    n_present = in_present;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_count   = '0;
                    n_res     = '0;
                    if (in_op == OP_CLAIM) begin
                        if (r_pause || (r_active >= r_limit)) begin
                            n_res.status = RES_BLOCK;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (in_op == OP_CANCEL) begin
                        n_state = S_SCAN;
                    end else if (in_op inside {OP_COMPLETE, OP_RETRY, OP_GET}) begin
                        if (in_range) begin
                            n_state = S_READ;
                        end else begin
                            n_res.status = RES_INVALID;
                            n_state      = S_DONE;
                        end
                    end else begin
                        n_res.status = RES_INVALID;
                        n_state      = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                // Evaluate the slot read last cycle while reading the next.
                if (r_op == OP_CLAIM) begin
                    if (hit) begin
                        mem_we             = 1'b1;
                        mem_wdata.state    = ST_RUNNING;
                        mem_wdata.started  = r_time;
                        mem_wdata.finished = 64'd0;
                        mem_wdata.result   = NO_RESULT;
                        n_active           = r_active + 5'd1;
                        n_res.status       = RES_OK;
                        n_res.claimed_slot = 4'(32'(r_eval_idx));
                        n_state            = S_DONE;
                    end else if (r_idx >= live_n) begin
                        n_res.status = RES_EMPTY;
                        n_state      = S_DONE;
                    end else begin
                        n_idx      = r_idx + CW'(1);
                        n_pend     = 1'b1;
                        n_eval_idx = r_idx[AW-1:0];
                    end
                end else begin
                    if (hit) begin
                        mem_we             = 1'b1;
                        mem_wdata.state    = ST_CANCELLED;
                        mem_wdata.finished = r_time;
                        mem_wdata.result   = CODE_CANCEL;
                        n_count            = count_inc;
                    end
                    if (r_idx >= live_n) begin
                        n_res.status          = RES_OK;
                        n_res.cancelled_count = hit ? count_inc : r_count;
                        n_state               = S_DONE;
                    end else begin
                        n_idx      = r_idx + CW'(1);
                        n_pend     = 1'b1;
                        n_eval_idx = r_idx[AW-1:0];
                    end
                end
            end

            S_READ: begin
                n_state = S_EXEC;
            end

            S_EXEC: begin
                mem_waddr = r_addr;
                n_state   = S_DONE;
                case (r_op)
                    OP_COMPLETE: begin
                        if ((eval_rec.state != ST_RUNNING) || (r_time < eval_rec.started) ||
                            ((r_code == CODE_SUCCESS) && !r_present)) begin
                            n_res.status = RES_INVALID;
                        end else begin
                            mem_we             = 1'b1;
                            mem_wdata.finished = r_time;
                            mem_wdata.result   = (r_code == NO_RESULT) ? CODE_CAPPED : r_code;
                            if (r_code == CODE_SUCCESS) begin
                                mem_wdata.state = ST_SUCCEEDED;
                            end else if (r_code == CODE_CANCEL) begin
                                mem_wdata.state = ST_CANCELLED;
                            end else begin
                                mem_wdata.state = ST_FAILED;
                            end
                            if (r_active != 5'd0) begin
                                n_active = r_active - 5'd1;
                            end
                            n_res.status = RES_OK;
                        end
                    end
                    OP_RETRY: begin
                        if (!(eval_rec.state inside {ST_FAILED, ST_CANCELLED}) ||
                            (eval_rec.retries == RETRY_MAX)) begin
                            n_res.status = RES_INVALID;
                        end else begin
                            mem_we             = 1'b1;
                            mem_wdata.state    = ST_QUEUED;
                            mem_wdata.started  = 64'd0;
                            mem_wdata.finished = 64'd0;
                            mem_wdata.retries  = eval_rec.retries + 32'd1;
                            mem_wdata.result   = NO_RESULT;
                            n_res.status       = RES_OK;
                        end
                    end
                    default: begin
                        n_res.status         = RES_OK;
                        n_res.slot_state_out = eval_rec.state;
                        n_res.slot_started   = eval_rec.started;
                        n_res.slot_finished  = eval_rec.finished;
                        n_res.slot_retries   = eval_rec.retries;
                        n_res.slot_result    = eval_rec.result;
                    end
                endcase
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 5'd0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_slots     <= SLOTS_RESET;
            r_limit     <= LIMIT_RESET;
            r_pause     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS: r_slots <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    CFG_PAUSE: r_pause <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and command registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_time     <= n_time;
        r_code     <= n_code;
        r_present  <= n_present;
        r_idx      <= n_idx;
        r_pend     <= n_pend;
        r_eval_idx <= n_eval_idx;
        r_count    <= n_count;
        r_res      <= n_res;
        if (out_load) begin
            r_out_data <= {2'b00, r_res.slot_result, r_res.slot_retries,
                           r_res.slot_finished, r_res.slot_started,
                           r_res.slot_state_out, r_res.cancelled_count,
                           r_res.claimed_slot, r_res.status};
        end
    end

    // Slot table memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_valid[rd_addr];
    end

    `include "job_slot_dispatcher_assert.svh"

    // Table writes happen only while a command is being worked on, at a
    // slot inside the table.
    `JSD_ASSERT_NOW(a_write_scope, i_clk, i_rst_n, mem_we,
        (32'(mem_waddr) < MAX_SLOTS) && ((r_state == S_SCAN) || (r_state == S_EXEC)),
        "slot table written outside a command or beyond its depth")

    // A claim that starts a slot raises the running count by one and ends.
    `JSD_ASSERT_NEXT(a_claim_count, i_clk, i_rst_n,
        (r_state == S_SCAN) && (r_op == OP_CLAIM) && mem_we,
        (r_active == $past(r_active) + 5'd1) && (r_state == S_DONE),
        "claim did not update the running count")

    // A loaded result is offered on the next cycle and the block is free.
    `JSD_ASSERT_NEXT(a_result_offered, i_clk, i_rst_n, out_load,
        m_axis_tvalid && s_axis_tready,
        "result not offered after load")

endmodule

// File: test/jsd_command_checker.sv
// Result checker for the job slot dispatcher testbench: predicts each result
// from the accepted commands and register writes, then compares it.
// Depends on jsd_pkg for the operation, state and status codes.
module jsd_command_checker
    import jsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [4:0]   i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // operation, slot_index, time_now, completion_code, status_present
    input  logic [79:0]  i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // status, claimed_slot, cancelled_count, slot_state_out, slot_started,
    // slot_finished, slot_retries, slot_result, zero fill
    input  logic [183:0] i_m_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_commands,
    output int           o_claims_started,
    output int           o_jobs_ended,
    output int           o_requeues,
    output int           o_swept
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the slot table and the registers.
    logic [4:0]  cfg_slots;
    logic [4:0]  cfg_limit;
    logic        cfg_pause;
    logic [2:0]  slot_phase    [MAX_SLOTS_DEF];
    logic [63:0] slot_begin    [MAX_SLOTS_DEF];
    logic [63:0] slot_end      [MAX_SLOTS_DEF];
    logic [31:0] slot_requeues [MAX_SLOTS_DEF];
    logic [7:0]  slot_code     [MAX_SLOTS_DEF];
    logic [4:0]  running_jobs;

    t_result expected_results [$];
    int      result_no;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_commands       = 0;
        o_claims_started = 0;
        o_jobs_ended     = 0;
        o_requeues       = 0;
        o_swept          = 0;
        result_no        = 0;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                             result_no, name, got, want));
        end
    endtask

    // Applies one command to the shadow table and returns its result.
    function automatic t_result run_command(input logic [79:0] word);
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [63:0] now;
        logic [7:0]  code;
        logic        present;
        logic [4:0]  live;
        logic        in_range;
        logic        found;
        int          count;
        t_result     r;
        op       = word[2:0];
        idx      = word[6:3];
        now      = word[70:7];
        code     = word[78:71];
        present  = word[79];
        live     = (cfg_slots > MAX_SLOTS_DEF) ? 5'(MAX_SLOTS_DEF) : cfg_slots;
        in_range = {1'b0, idx} < live;
        found    = 1'b0;
        count    = 0;
        r        = '0;
        case (op)
            OP_CLAIM: begin
                if (cfg_pause || running_jobs >= cfg_limit) begin
                    r.status = RES_BLOCK;
                end else begin
                    r.status = RES_EMPTY;
                    for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
                        if (!found && i < live && slot_phase[i] == ST_QUEUED) begin
                            found          = 1'b1;
                            slot_phase[i]  = ST_RUNNING;
                            slot_begin[i]  = now;
                            slot_end[i]    = '0;
                            slot_code[i]   = NO_RESULT;
                            running_jobs   = running_jobs + 1'b1;
                            r.status       = RES_OK;
                            r.claimed_slot = 4'(i);
                            o_claims_started++;
                        end
                    end
                end
            end
            OP_COMPLETE: begin
                if (!in_range || slot_phase[idx] != ST_RUNNING || now < slot_begin[idx]
                        || (code == CODE_SUCCESS && !present)) begin
                    r.status = RES_INVALID;
                end else begin
                    // An all-ones failure code would read back as "no result yet".
                    slot_code[idx] = (code == NO_RESULT) ? CODE_CAPPED : code;
                    if (code == CODE_SUCCESS) begin
                        slot_phase[idx] = ST_SUCCEEDED;
                    end else if (code == CODE_CANCEL) begin
                        slot_phase[idx] = ST_CANCELLED;
                    end else begin
                        slot_phase[idx] = ST_FAILED;
                    end
                    slot_end[idx] = now;
                    if (running_jobs != 0) begin
                        running_jobs = running_jobs - 1'b1;
                    end
                    r.status = RES_OK;
                    o_jobs_ended++;
                end
            end
            OP_CANCEL: begin
                for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
                    if (i < live && slot_phase[i] == ST_QUEUED) begin
                        slot_phase[i] = ST_CANCELLED;
                        slot_code[i]  = CODE_CANCEL;
                        slot_end[i]   = now;
                        count++;
                    end
                end
                r.status          = RES_OK;
                r.cancelled_count = (count > COUNT_MAX) ? COUNT_MAX : 5'(count);
                o_swept += count;
            end
            OP_RETRY: begin
                if (!in_range
                        || (slot_phase[idx] != ST_FAILED && slot_phase[idx] != ST_CANCELLED)
                        || slot_requeues[idx] == RETRY_MAX) begin
                    r.status = RES_INVALID;
                end else begin
                    slot_requeues[idx] = slot_requeues[idx] + 1'b1;
                    slot_phase[idx]    = ST_QUEUED;
                    slot_code[idx]     = NO_RESULT;
                    slot_begin[idx]    = '0;
                    slot_end[idx]      = '0;
                    r.status           = RES_OK;
                    o_requeues++;
                end
            end
            OP_GET: begin
                if (!in_range) begin
                    r.status = RES_INVALID;
                end else begin
                    r.status         = RES_OK;
                    r.slot_state_out = slot_phase[idx];
                    r.slot_started   = slot_begin[idx];
                    r.slot_finished  = slot_end[idx];
                    r.slot_retries   = slot_requeues[idx];
                    r.slot_result    = slot_code[idx];
                end
            end
            default: begin
                r.status = RES_INVALID;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_slots    = SLOTS_RESET;
            cfg_limit    = LIMIT_RESET;
            cfg_pause    = 1'b0;
            running_jobs = '0;
            for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
                slot_phase[i]    = ST_QUEUED;
                slot_begin[i]    = '0;
                slot_end[i]      = '0;
                slot_requeues[i] = '0;
                slot_code[i]     = NO_RESULT;
            end
            expected_results.delete();
            o_pending = 0;
        end else begin
            // Results first: a result accepted now always belongs to an older command.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("result %0d arrived with no command waiting",
                                     result_no));
                end else begin
                    want                = expected_results.pop_front();
                    got                 = '0;
                    got.status          = i_m_tdata[1:0];
                    got.claimed_slot    = i_m_tdata[5:2];
                    got.cancelled_count = i_m_tdata[10:6];
                    got.slot_state_out  = i_m_tdata[13:11];
                    got.slot_started    = i_m_tdata[77:14];
                    got.slot_finished   = i_m_tdata[141:78];
                    got.slot_retries    = i_m_tdata[173:142];
                    got.slot_result     = i_m_tdata[181:174];
                    check_field("status", got.status, want.status);
                    check_field("claimed_slot", got.claimed_slot, want.claimed_slot);
                    check_field("cancelled_count", got.cancelled_count,
                                want.cancelled_count);
                    check_field("slot_state_out", got.slot_state_out,
                                want.slot_state_out);
                    check_field("slot_started", got.slot_started, want.slot_started);
                    check_field("slot_finished", got.slot_finished, want.slot_finished);
                    check_field("slot_retries", got.slot_retries, want.slot_retries);
                    check_field("slot_result", got.slot_result, want.slot_result);
                end
                result_no++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOTS: cfg_slots = i_cfg_data;
                    CFG_LIMIT: cfg_limit = i_cfg_data;
                    CFG_PAUSE: cfg_pause = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(run_command(i_s_tdata));
                o_commands++;
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// File: test/job_slot_dispatcher_test.sv
// Top of the job slot dispatcher testbench: clock, reset, command and result
// traffic, register settings and the verdict. Depends on jsd_pkg, the
// job_slot_dispatcher RTL and jsd_command_checker.
module job_slot_dispatcher_test;
    timeunit 1ns;
    timeprecision 1ps;
    import jsd_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 10;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASES       = 12;
    localparam int          PHASE_ITEMS  = 115;
    // Several times the slowest legal run; the run never gets close.
    localparam longint      TIMEOUT_NS   = 5_000_000;
    // The write port decodes four indexes, but only three registers exist.
    localparam logic [1:0]  CFG_SPARE    = 2'd3;
    localparam logic [63:0] TIME_MAX     = '1;
    // Operation codes with no meaning; the block must refuse them.
    localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [4:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [183:0] m_axis_tdata;

    int fail_count;
    int pending;
    int commands;
    int claims_started;
    int jobs_ended;
    int requeues;
    int swept;

    // Stimulus bookkeeping. The top only tracks what it wrote itself.
    logic [63:0] clock_ms;
    int          live_now;
    int          settings_used;
    int          sent;
    logic        calm;
    logic        hold_request;

    // Register settings of the random phases: slots in use, concurrency
    // limit, pause. Extremes sit among ordinary values: one slot, a limit of
    // zero, a limit above the slot count, a slot count above the table, a
    // paused phase where every claim must be refused.
    int unsigned phase_slots [PHASES] = '{4, 2, 16, 8, 1, 6, 31, 3, 16, 5, 12, 4};
    int unsigned phase_limit [PHASES] = '{2, 1, 16, 3, 1, 31, 4, 2, 1, 0, 6, 4};
    int unsigned phase_pause [PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0};

    job_slot_dispatcher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    jsd_command_checker result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_commands       (commands),
        .o_claims_started (claims_started),
        .o_jobs_ended     (jobs_ended),
        .o_requeues       (requeues),
        .o_swept          (swept)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Safety net against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: the run did not finish in %0d ns.", TIMEOUT_NS);
        $display("job_slot_dispatcher_test NOT OK");
        $finish;
    end

    // Result side. Ready comes in random bursts; on request it drops for a
    // long counted stretch so the block fills and back-pressures commands.
    // Once the run goes calm it stays high.
    initial begin
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge i_clk);
            end
        end
    end

    function automatic logic [79:0] command_word(input logic [2:0] op,
            input logic [3:0] idx, input logic [63:0] now, input logic [7:0] code,
            input logic present);
        return {present, code, now, idx, op};
    endfunction

    // Random command, biased toward well-formed traffic: slots mostly inside
    // the live range and a time base that only moves forward, so completes
    // usually find their job running and started earlier. Success is kept
    // rare because a succeeded slot can never be requeued. A share of the
    // items is raw noise over all 80 bits, plus the unused operation codes.
    function automatic logic [79:0] random_command();
        int unsigned pick;
        int unsigned roll;
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [63:0] now;
        logic [7:0]  code;
        logic        present;
        pick     = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 40);
        roll     = $urandom_range(0, 99);
        if (live_now != 0 && roll < 85) begin
            idx = 4'($urandom_range(0, live_now - 1));
        end else begin
            idx = 4'($urandom_range(0, 15));
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            now = TIME_MAX;
        end else if (roll < 16) begin
            now = {$urandom, $urandom};
        end else begin
            now = clock_ms;
        end
        code    = 8'($urandom);
        present = 1'($urandom);
        if (pick < 24) begin
            op = OP_CLAIM;
        end else if (pick < 52) begin
            op   = OP_COMPLETE;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                code    = CODE_SUCCESS;
                present = ($urandom_range(0, 9) != 0);
            end else if (roll < 40) begin
                code = CODE_CANCEL;
            end else if (roll < 50) begin
                code = NO_RESULT;
            end else begin
                code = 8'($urandom_range(2, 254));
            end
        end else if (pick < 66) begin
            op = OP_RETRY;
        end else if (pick < 86) begin
            op = OP_GET;
        end else if (pick < 92) begin
            op = OP_CANCEL;
        end else if (pick < 97) begin
            return {16'($urandom), $urandom, $urandom};
        end else begin
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return command_word(op, idx, now, code, present);
    endfunction

    // Offers one command transaction and returns at the falling edge after it
    // was taken. Valid drops there and is raised again at once when the next
    // command follows without a gap.
    task automatic issue_command(input logic [79:0] word);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        sent++;
    endtask

    // Every result produced, then a spare wait for the block to settle.
    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [4:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Registers may only change while the block is idle.
    task automatic apply_setting(input logic [4:0] slots, input logic [4:0] limit,
                                 input logic [4:0] paused);
        wait_idle();
        write_reg(CFG_SLOTS, slots);
        write_reg(CFG_LIMIT, limit);
        write_reg(CFG_PAUSE, paused);
        live_now = (slots > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(slots);
        settings_used++;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SLOTS;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        hold_request  = 1'b0;
        sent          = 0;
        settings_used = 0;
        live_now      = MAX_SLOTS_DEF;
        clock_ms      = {32'd0, $urandom};
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part on a four-slot table with two jobs allowed at once.
        apply_setting(5'd4, 5'd2, 5'd0);
        // A slot read straight after reset, and one beyond the live range.
        issue_command(command_word(OP_GET, 4'd0, '0, '0, 1'b0));
        issue_command(command_word(OP_GET, 4'd15, '0, '0, 1'b0));
        // Two claims fill the limit; the third must be refused.
        issue_command(command_word(OP_CLAIM, 4'd0, 64'd100, '0, 1'b0));
        issue_command(command_word(OP_CLAIM, 4'd0, TIME_MAX, '0, 1'b0));
        issue_command(command_word(OP_CLAIM, 4'd0, 64'd101, '0, 1'b0));
        // Finish before start, and success without a status, are rejected.
        issue_command(command_word(OP_COMPLETE, 4'd0, 64'd50, CODE_SUCCESS, 1'b1));
        issue_command(command_word(OP_COMPLETE, 4'd0, 64'd200, CODE_SUCCESS, 1'b0));
        issue_command(command_word(OP_COMPLETE, 4'd0, 64'd200, CODE_SUCCESS, 1'b1));
        // An all-ones failure code is stored one lower.
        issue_command(command_word(OP_COMPLETE, 4'd1, TIME_MAX, NO_RESULT, 1'b0));
        issue_command(command_word(OP_GET, 4'd1, '0, '0, 1'b0));
        issue_command(command_word(OP_COMPLETE, 4'd2, 64'd300, 8'd7, 1'b1));
        // Requeue a failed slot; a succeeded one cannot be requeued.
        issue_command(command_word(OP_RETRY, 4'd1, '0, '0, 1'b0));
        issue_command(command_word(OP_RETRY, 4'd0, '0, '0, 1'b0));
        issue_command(command_word(OP_CLAIM, 4'd0, 64'd5, '0, 1'b0));
        issue_command(command_word(OP_COMPLETE, 4'd1, 64'd7, CODE_CANCEL, 1'b1));
        // Cancel sweeps the two untouched slots; nothing is left to claim.
        issue_command(command_word(OP_CANCEL, 4'd0, 64'd9, '0, 1'b0));
        issue_command(command_word(OP_CLAIM, 4'd0, 64'd10, '0, 1'b0));
        issue_command(command_word(OP_GET, 4'd3, '0, '0, 1'b0));
        issue_command(command_word(OP_SPARE_LO, 4'd2, TIME_MAX, 8'hA5, 1'b1));
        issue_command(command_word(OP_SPARE_HI, 4'd15, TIME_MAX, 8'hFF, 1'b1));
        issue_command(command_word(OP_RETRY, 4'd3, '0, '0, 1'b0));
        issue_command(command_word(OP_GET, 4'd3, '0, '0, 1'b0));
        // Paused: claims are refused even with room under the limit.
        apply_setting(5'd4, 5'd2, 5'd1);
        issue_command(command_word(OP_CLAIM, 4'd0, 64'd11, '0, 1'b0));
        // No live slots at all: nothing to claim, read or cancel.
        apply_setting(5'd0, 5'd16, 5'd0);
        issue_command(command_word(OP_CLAIM, 4'd0, 64'd12, '0, 1'b0));
        issue_command(command_word(OP_GET, 4'd0, '0, '0, 1'b0));
        issue_command(command_word(OP_CANCEL, 4'd0, 64'd13, '0, 1'b0));
        // A slot count above the table depth is clipped to the table depth;
        // the spare register index must leave everything alone.
        apply_setting(5'd31, 5'd1, 5'd0);
        write_reg(CFG_SPARE, 5'h1F);
        issue_command(command_word(OP_GET, 4'd15, '0, '0, 1'b0));

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            apply_setting(5'(phase_slots[p]), 5'(phase_limit[p]), 5'(phase_pause[p]));
            // One long result stall on a wide-open setting fills the block.
            if (p == 2) begin
                hold_request = 1'b1;
            end
            // The last phase runs with no idling on either side.
            if (p == PHASES - 1) begin
                calm = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                issue_command(random_command());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending != 0) begin
            $display("ERROR: %0d results never arrived.", pending);
        end
        $display("Sent %0d commands under %0d register settings, with one %0d-cycle result stall.",
                 sent, settings_used, HOLD_CYCLES);
        $display("Jobs started %0d, ended %0d, requeued %0d; cancels swept %0d queued slots.",
                 claims_started, jobs_ended, requeues, swept);
        if (fail_count == 0 && pending == 0) begin
            $display("job_slot_dispatcher_test OK");
        end else begin
            $display("job_slot_dispatcher_test NOT OK");
        end
        $finish;
    end

endmodule
